### sv/scrolling_text_frame_buffer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scrolling text frame buffer
// Shared concurrent assertion forms with clock and reset passed in.
// ----------------------------------------------------------------------------
`ifndef SCROLLING_TEXT_FRAME_BUFFER_MACROS_SVH
`define SCROLLING_TEXT_FRAME_BUFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STFB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define STFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed in the next cycle");

`endif

### sv/stfb_pkg.sv
// ----------------------------------------------------------------------------
// Scrolling text frame buffer package
// Command codes, pending action codes, transaction types and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package stfb_pkg;

	localparam int ROWS = 8;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_SHIFT = 2'd1;
	localparam logic [1:0] PEND_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] glyph;
		logic        last_char;
		logic [2:0]  row_sel;
		logic [5:0]  col_sel;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       char_taken;
		logic       scroll_done;
	} result_t;

	function automatic logic [7:0] reverse8(input logic [7:0] v);
		logic [7:0] r;
		for (int k = 0; k < 8; k++) begin
			r[7 - k] = v[k];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/stfb_chan_if.sv
// ----------------------------------------------------------------------------
// Scrolling text frame buffer channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface stfb_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/stfb_core.sv
// ----------------------------------------------------------------------------
// Scrolling text frame buffer core
// Frame rows, scroll state and the single-pass command logic.
// ----------------------------------------------------------------------------
`default_nettype none

module stfb_core #(
	parameter int COLS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  stfb_pkg::item_t  item,
	output stfb_pkg::result_t res
);
	import stfb_pkg::*;

	localparam int ROW_BITS = 8 * COLS;
	localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
	localparam logic [9:0] DRAIN_INIT = 10'(8 * COLS);

	logic [ROW_BITS-1:0] frame_q [ROWS];
	logic [ROW_BITS-1:0] settled [ROWS];
	logic [ROW_BITS-1:0] frame_d [ROWS];
	logic [2:0]          bit_pos_q, bit_pos_d;
	logic                finished_q, finished_d;
	logic [9:0]          drain_q, drain_d, drain_dec;
	logic [1:0]          pend_q, pend_d;
	logic                col_ok;
	logic [COL_W-1:0]    col_idx;

	assign col_ok    = {1'b0, item.col_sel} < 7'(COLS);
	assign col_idx   = COL_W'(item.col_sel);
	assign drain_dec = drain_q - 10'd1;

	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			if (pend_q == PEND_CLEAR) begin
				settled[r] = '0;
			end else if (pend_q == PEND_SHIFT) begin
				settled[r] = frame_q[r] << 1;
			end else begin
				settled[r] = frame_q[r];
			end
		end

		frame_d    = frame_q;
		bit_pos_d  = bit_pos_q;
		finished_d = finished_q;
		drain_d    = drain_q;
		pend_d     = pend_q;
		res        = '0;

		case (item.cmd)
			CMD_TICK: begin
				frame_d = settled;
				if (!finished_q) begin
					for (int r = 0; r < ROWS; r++) begin
						frame_d[r][0] = item.glyph[{3'(r), bit_pos_q}];
					end
					bit_pos_d = bit_pos_q + 3'd1;
					if (bit_pos_q == 3'd7) begin
						res.char_taken = 1'b1;
						if (item.last_char) begin
							finished_d = 1'b1;
						end
					end
				end
				pend_d = PEND_SHIFT;
				if (finished_d) begin
					drain_d = drain_dec;
					if (drain_dec == 10'd0) begin
						bit_pos_d       = 3'd0;
						finished_d      = 1'b0;
						drain_d         = DRAIN_INIT;
						pend_d          = PEND_CLEAR;
						res.scroll_done = 1'b1;
					end
				end
			end
			CMD_LOAD: begin
				frame_d = settled;
				if (col_ok) begin
					for (int r = 0; r < ROWS; r++) begin
						for (int c = 0; c < COLS; c++) begin
							if (col_idx == COL_W'(c)) begin
								frame_d[r][(COLS-1-c)*8 +: 8] =
									reverse8(item.glyph[r*8 +: 8]);
							end
						end
					end
				end
				pend_d = PEND_NONE;
			end
			CMD_READ: begin
				if (col_ok) begin
					for (int c = 0; c < COLS; c++) begin
						if (col_idx == COL_W'(c)) begin
							res.read_data = frame_q[item.row_sel][(COLS-1-c)*8 +: 8];
						end
					end
				end
			end
			CMD_CLEAR: begin
				for (int r = 0; r < ROWS; r++) begin
					frame_d[r] = '0;
				end
				pend_d = PEND_NONE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				frame_q[r] <= '0;
			end
			bit_pos_q  <= 3'd0;
			finished_q <= 1'b0;
			drain_q    <= DRAIN_INIT;
			pend_q     <= PEND_NONE;
		end else if (fire) begin
			frame_q    <= frame_d;
			bit_pos_q  <= bit_pos_d;
			finished_q <= finished_d;
			drain_q    <= drain_d;
			pend_q     <= pend_d;
		end
	end

endmodule

`default_nettype wire

### sv/scrolling_text_frame_buffer.sv
// ----------------------------------------------------------------------------
// Scrolling text frame buffer
// Marquee frame of 8 rows by COLS bytes with scroll, load, read and clear.
// ----------------------------------------------------------------------------
// Commands arrive on the item channel and every transaction yields exactly one
// transaction on the result channel, in order. A scroll tick shifts the frame
// left by one pixel and injects one column of the presented glyph; char_taken
// asks for the next glyph and scroll_done marks the end of the drain. A static
// load writes one glyph column, a read returns one frame byte and a clear
// zeroes the frame.
// An accepted item waits in one input register, the whole command is
// evaluated combinationally from it, and its outcome is captured in one
// result register. Throughput is one transaction per cycle while the
// receiver keeps taking results, since every row shifts in parallel in its
// own register.
// Reset clears the frame and the scroll state; both channels come up empty.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; after that item.ready drops until results drain.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scrolling_text_frame_buffer_macros.svh"

module scrolling_text_frame_buffer #(
	parameter int COLS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	stfb_chan_if.sink    item,
	stfb_chan_if.source  result
);
	import stfb_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	logic    fire;
	logic    out_valid_q;
	result_t res_q;
	result_t core_res;

	assign advance    = !out_valid_q || result.ready;
	assign fire       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.payload;
		end
	end

	stfb_core #(
		.COLS(COLS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.item(item_s1),
		.res(core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= core_res;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = res_q;

	`STFB_ASSERT_NEXT(a_stall_holds, clk, arst_n,
		valid_s1 && !advance, valid_s1 && $stable(item_s1))
	`STFB_ASSERT_SAME(a_flags_on_tick, clk, arst_n,
		fire && (item_s1.cmd != CMD_TICK), !core_res.char_taken && !core_res.scroll_done)
	`STFB_ASSERT_SAME(a_data_on_read, clk, arst_n,
		fire && (item_s1.cmd != CMD_READ), core_res.read_data == 8'd0)

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Scrolling text frame buffer testbench
// Drives scroll, load, read and clear commands through the item channel and
// checks every result transaction against a cycle-free model of the frame.
// A short directed part covers field extremes, out of range columns, reads
// before a pending shift, clears that keep the scroll state, and loads that
// settle a pending shift. The random part is mostly complete texts with their
// full drain, mixed with reads and short runs of arbitrary commands. Both
// channels idle at random in the first two of three phases, the receiver
// holds off once long enough to stall the input, and the sender pauses once
// until all results have drained.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stfb_pkg::*;

	localparam int COLS = 16;
	localparam int RANDOM_ITEMS = 300;
	localparam int HOLD_CYCLES = 60;
	localparam int MAX_REPORTS = 10;

	logic clk;
	logic arst_n;

	stfb_chan_if #(.payload_t(item_t)) item_ch ();
	stfb_chan_if #(.payload_t(result_t)) result_ch ();

	scrolling_text_frame_buffer #(.COLS(COLS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	logic [COLS*8-1:0] frame_row [ROWS];
	logic [2:0]        bit_pos;
	logic              text_done;
	logic [9:0]        drain_left;
	logic [1:0]        pending_act;

	item_t   pending_items [$];
	result_t expected_results [$];

	logic item_fire;
	int   offered;
	int   results_seen;
	int   mismatches;
	int   phase1_end;
	int   phase2_end;
	int   hold_at;
	int   pause_at;
	int   hold_left;
	bit   hold_started;

	always #1 clk = ~clk;

	function automatic void settle_frame();
		for (int r = 0; r < ROWS; r++) begin
			if (pending_act == PEND_CLEAR) begin
				frame_row[r] = '0;
			end else if (pending_act == PEND_SHIFT) begin
				frame_row[r] = frame_row[r] << 1;
			end
		end
		pending_act = PEND_NONE;
	endfunction

	function automatic result_t frame_step(item_t it);
		result_t    res;
		logic [7:0] grow;
		logic [7:0] rev;
		int         base;
		res = '0;
		base = (COLS - 1 - int'(it.col_sel)) * 8;
		case (it.cmd)
			CMD_TICK: begin
				settle_frame();
				if (!text_done) begin
					for (int r = 0; r < ROWS; r++) begin
						grow = it.glyph[8*r +: 8];
						frame_row[r][0] = grow[bit_pos];
					end
					bit_pos = bit_pos + 3'd1;
					if (bit_pos == 3'd0) begin
						res.char_taken = 1'b1;
						if (it.last_char) begin
							text_done = 1'b1;
						end
					end
				end
				pending_act = PEND_SHIFT;
				if (text_done) begin
					drain_left = drain_left - 10'd1;
					if (drain_left == 10'd0) begin
						bit_pos = '0;
						text_done = 1'b0;
						drain_left = 10'(8 * COLS);
						pending_act = PEND_CLEAR;
						res.scroll_done = 1'b1;
					end
				end
			end
			CMD_LOAD: begin
				settle_frame();
				if (it.col_sel < COLS) begin
					for (int r = 0; r < ROWS; r++) begin
						grow = it.glyph[8*r +: 8];
						for (int k = 0; k < 8; k++) begin
							rev[7 - k] = grow[k];
						end
						frame_row[r][base +: 8] = rev;
					end
				end
			end
			CMD_READ: begin
				if (it.col_sel < COLS) begin
					res.read_data = frame_row[it.row_sel][base +: 8];
				end
			end
			CMD_CLEAR: begin
				for (int r = 0; r < ROWS; r++) begin
					frame_row[r] = '0;
				end
				pending_act = PEND_NONE;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic item_t rand_item(logic [1:0] cmd);
		item_t it;
		it.cmd = cmd;
		it.glyph = {$urandom(), $urandom()};
		it.last_char = 1'($urandom_range(1));
		it.row_sel = 3'($urandom_range(7));
		if ($urandom_range(7) == 0) begin
			it.col_sel = 6'($urandom_range(63));
		end else begin
			it.col_sel = 6'($urandom_range(COLS - 1));
		end
		return it;
	endfunction

	function automatic void add_item(logic [1:0] cmd, logic [63:0] glyph, logic last_char,
			logic [2:0] row_sel, logic [5:0] col_sel);
		pending_items.push_back(item_t'{cmd, glyph, last_char, row_sel, col_sel});
	endfunction

	function automatic void add_side_items();
		int pick;
		pick = $urandom_range(59);
		if (pick < 12) begin
			pending_items.push_back(rand_item(CMD_READ));
		end else if (pick == 12) begin
			pending_items.push_back(rand_item(CMD_LOAD));
		end else if (pick == 13) begin
			pending_items.push_back(rand_item(CMD_CLEAR));
		end
	endfunction

	function automatic int idle_pct(bit receiver);
		if (offered < phase1_end) begin
			return receiver ? 88 : 7;
		end
		if (offered < phase2_end) begin
			return receiver ? 7 : 88;
		end
		return 0;
	endfunction

	always @(negedge clk) begin
		if (arst_n && (!item_ch.valid || item_fire)) begin
			if (pending_items.size() != 0 &&
					!(offered == pause_at && expected_results.size() != 0) &&
					$urandom_range(99) >= idle_pct(1'b0)) begin
				item_ch.payload <= pending_items.pop_front();
				item_ch.valid <= 1'b1;
				offered++;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_started && results_seen >= hold_at) begin
				hold_started = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= idle_pct(1'b1));
			end
		end
	end

	always @(posedge clk) begin : monitor
		result_t want;
		if (!arst_n) begin
			item_fire <= 1'b0;
		end else begin
			item_fire <= item_ch.valid && item_ch.ready;
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("unexpected result: data %h taken %b done %b",
							result_ch.payload.read_data, result_ch.payload.char_taken,
							result_ch.payload.scroll_done);
					end
				end else begin
					want = expected_results.pop_front();
					if (result_ch.payload !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("mismatch %0d: data %h/%h taken %b/%b done %b/%b",
								results_seen, want.read_data, result_ch.payload.read_data,
								want.char_taken, result_ch.payload.char_taken,
								want.scroll_done, result_ch.payload.scroll_done);
						end
					end
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				expected_results.push_back(frame_step(item_ch.payload));
			end
		end
	end

	initial begin : stimulus
		item_t it;
		int    n_chars;
		int    n_directed;
		clk = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		result_ch.ready = 1'b0;
		for (int r = 0; r < ROWS; r++) begin
			frame_row[r] = '0;
		end
		bit_pos = '0;
		text_done = 1'b0;
		drain_left = 10'(8 * COLS);
		pending_act = PEND_NONE;
		offered = 0;
		results_seen = 0;
		mismatches = 0;
		hold_left = 0;
		hold_started = 1'b0;

		add_item(CMD_READ, '0, 1'b0, 3'd0, 6'd0);
		add_item(CMD_LOAD, '1, 1'b1, 3'd7, 6'd0);
		add_item(CMD_LOAD, 64'h0123_4567_89AB_CDEF, 1'b0, 3'd0, 6'(COLS - 1));
		add_item(CMD_LOAD, '1, 1'b0, 3'd0, 6'(COLS));
		add_item(CMD_LOAD, 64'h8040_2010_0804_0201, 1'b1, 3'd0, 6'd63);
		add_item(CMD_READ, '0, 1'b0, 3'd0, 6'd0);
		add_item(CMD_READ, '1, 1'b1, 3'd7, 6'(COLS - 1));
		add_item(CMD_READ, '0, 1'b0, 3'd3, 6'(COLS - 1));
		add_item(CMD_READ, '0, 1'b0, 3'd7, 6'(COLS));
		add_item(CMD_READ, '0, 1'b0, 3'd3, 6'd63);
		add_item(CMD_TICK, 64'hA5C3_0FF0_5A3C_F00F, 1'b0, 3'd0, 6'd0);
		add_item(CMD_READ, '0, 1'b0, 3'd0, 6'(COLS - 1));
		add_item(CMD_READ, '0, 1'b0, 3'd0, 6'(COLS - 2));
		add_item(CMD_CLEAR, '1, 1'b1, 3'd7, 6'd63);
		add_item(CMD_READ, '0, 1'b0, 3'd7, 6'(COLS - 1));
		for (int b = 0; b < 7; b++) begin
			add_item(CMD_TICK, 64'hFFFF_0000_F0F0_3355, 1'b0, 3'd0, 6'd0);
		end
		add_item(CMD_LOAD, 64'h1122_3344_5566_7788, 1'b0, 3'd0, 6'd8);
		add_item(CMD_READ, '0, 1'b0, 3'd5, 6'd8);
		add_item(CMD_READ, '0, 1'b0, 3'd2, 6'(COLS - 1));
		n_directed = pending_items.size();

		while (pending_items.size() < n_directed + RANDOM_ITEMS) begin
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(15, 4)) begin
					pending_items.push_back(rand_item(2'($urandom_range(3))));
				end
			end else begin
				n_chars = $urandom_range(3, 1);
				for (int c = 0; c < n_chars; c++) begin
					it = rand_item(CMD_TICK);
					it.last_char = (c == n_chars - 1);
					for (int b = 0; b < 8; b++) begin
						add_side_items();
						pending_items.push_back(it);
					end
				end
				for (int d = 0; d < 8 * COLS; d++) begin
					add_side_items();
					pending_items.push_back(rand_item(CMD_TICK));
				end
			end
		end

		phase1_end = pending_items.size() / 3;
		phase2_end = 2 * pending_items.size() / 3;
		hold_at = phase2_end + 20;
		pause_at = phase2_end + 100;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASS scrolling_text_frame_buffer");
		end else begin
			$display("FAIL scrolling_text_frame_buffer");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("FAIL scrolling_text_frame_buffer");
		$finish;
	end

endmodule
